[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

[rtl/core/gbai_pkg.sv]
// Package: field widths, register indexes, function codes and state type.
`default_nettype none

package gbai_pkg;

    // Field widths
    localparam int COORD_W     = 16;
    localparam int ID_W        = 16;
    localparam int SIZE_W      = 15;
    localparam int GRID_W      = 4;
    localparam int OUT_IDX_W   = 3;
    localparam int SLOT_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Records per insert are capped at this count
    localparam int MAX_RESULTS = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 3'd5;

    // Item function codes
    localparam logic FUNC_CLEAR  = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_WR
    } t_state;

endpackage

`default_nettype wire

[rtl/core/gbai_if.sv]
// Interfaces: item input, record output and configuration write channels.
`default_nettype none

interface gbai_in_if;
    import gbai_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [ID_W-1:0]           collider_id;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;

    modport source (output valid, func, collider_id, min_x, min_y, max_x, max_y,
                    input ready);
    modport sink   (input valid, func, collider_id, min_x, min_y, max_x, max_y,
                    output ready);
endinterface

interface gbai_out_if;
    import gbai_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] cell_x;
    logic [OUT_IDX_W-1:0] cell_y;
    logic [ID_W-1:0]      echo_id;
    logic [SLOT_W-1:0]    slot;
    logic                 overflow;
    logic                 last;

    modport source (output valid, cell_x, cell_y, echo_id, slot, overflow, last,
                    input ready);
    modport sink   (input valid, cell_x, cell_y, echo_id, slot, overflow, last,
                    output ready);
endinterface

interface gbai_cfg_if;
    import gbai_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/gbai_bin_div.sv]
// Bin lane: floor((coord - origin) / size) clamped to 0..lim, one quotient bit a cycle.
`default_nettype none

module gbai_bin_div #(
    parameter int IDX_W = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [gbai_pkg::COORD_W-1:0] i_coord,
    input  logic signed [gbai_pkg::COORD_W-1:0] i_origin,
    input  logic [gbai_pkg::SIZE_W-1:0]        i_size,
    input  logic [IDX_W-1:0]                   i_lim,
    output logic                               o_done,
    output logic [IDX_W-1:0]                   o_bin
);
    import gbai_pkg::*;

    localparam int DW = SIZE_W + IDX_W;
    localparam int CW = $clog2(IDX_W + 1) > 0 ? $clog2(IDX_W + 1) : 1;

    logic [COORD_W:0]    diff;
    logic [SIZE_W-1:0]   size_eff;
    logic                ge;
    logic                r_busy;
    logic                r_neg;
    logic [CW-1:0]       r_cnt;
    logic [DW-1:0]       r_rem;
    logic [DW-1:0]       r_div;
    logic [IDX_W:0]      r_quo;

    // Exact difference, then a zero size counts as one
    assign diff     = {i_coord[COORD_W-1], i_coord} - {i_origin[COORD_W-1], i_origin};
    assign size_eff = (i_size == '0) ? SIZE_W'(1) : i_size;
    assign ge       = (r_rem >= r_div);

    // Restoring division: first step tests the saturation bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(IDX_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= diff[COORD_W];
            r_rem <= DW'(diff[COORD_W-1:0]);
            r_div <= {size_eff, {IDX_W{1'b0}}};
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
            r_quo <= {r_quo[IDX_W-1:0], ge};
        end
    end

    // Clamp: negative to zero, large quotient to the last active index
    always_comb begin
        if (r_neg) begin
            o_bin = '0;
        end else if (r_quo[IDX_W] || (r_quo[IDX_W-1:0] > i_lim)) begin
            o_bin = i_lim;
        end else begin
            o_bin = r_quo[IDX_W-1:0];
        end
    end

    assign o_done = !r_busy;

endmodule

`default_nettype wire

[rtl/core/gbai_cell_mem.sv]
// Cell memories: per-cell fill counts (read and written) and the id store.
`default_nettype none

module gbai_cell_mem #(
    parameter int NUM_CELLS     = 64,
    parameter int CELL_CAPACITY = 16,
    localparam int AW  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1,
    localparam int FW  = $clog2(CELL_CAPACITY + 1),
    localparam int SAW = (NUM_CELLS * CELL_CAPACITY > 1) ?
                         $clog2(NUM_CELLS * CELL_CAPACITY) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [FW-1:0]              o_rd_data,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic                       i_fill_we,
    input  logic [FW-1:0]              i_fill_data,
    input  logic                       i_store_we,
    input  logic [FW-1:0]              i_store_slot,
    input  logic [gbai_pkg::ID_W-1:0]  i_store_data
);
    import gbai_pkg::*;

    logic [FW-1:0]   mem_fill [NUM_CELLS];
    logic [ID_W-1:0] mem_store [NUM_CELLS * CELL_CAPACITY];
    logic [SAW-1:0]  store_addr;

    // Id slot address: cell * capacity + slot
    assign store_addr = SAW'(int'(i_wr_addr) * CELL_CAPACITY + int'(i_store_slot));

    // Fill counts: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_fill_we) begin
            mem_fill[i_wr_addr] <= i_fill_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem_fill[i_rd_addr];
        end
    end

    // Id store: write only
    always_ff @(posedge i_clk) begin
        if (i_store_we) begin
            mem_store[store_addr] <= i_store_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/grid_bin_aabb_insert_unit.sv]
// Top level: uniform-grid box binning with config registers, bin lanes and fill memory.
//
//   channel   dir   transaction
//   i_cfg     in    register index + write data
//   i_in      in    func, collider_id, box corners (Q12.4)
//   o_out     out   cell_x, cell_y, echo_id, slot, overflow, last
//
// Insert: the item is accepted, then clog2(max(MAX_COLS, MAX_ROWS)) + 1 divide steps,
//   then the bins are taken, then each covered cell gets a fill-count read and a
//   write-back.
// Clear item or grid size write: one cell per cycle, all MAX_COLS * MAX_ROWS cells (64).
// Reset (synchronous, active low) runs the same clearing pass; i_in.ready stays low.
// A stalled record holds the write step; a new item can be taken while a last record waits.
`default_nettype none

`include "assert_macros.svh"

module grid_bin_aabb_insert_unit #(
    parameter int MAX_COLS      = 8,
    parameter int MAX_ROWS      = 8,
    parameter int CELL_CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbai_cfg_if.sink    i_cfg,
    gbai_in_if.sink     i_in,
    gbai_out_if.source  o_out
);
    import gbai_pkg::*;

    localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
    localparam int XW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int FW = $clog2(CELL_CAPACITY + 1);
    localparam int NW = $clog2(MAX_RESULTS);

    // Configuration registers
    logic signed [COORD_W-1:0] r_origin_x;
    logic signed [COORD_W-1:0] r_origin_y;
    logic [SIZE_W-1:0]         r_cell_w;
    logic [SIZE_W-1:0]         r_cell_h;
    logic [GRID_W-1:0]         r_cols;
    logic [GRID_W-1:0]         r_rows;

    logic cfg_acc;
    logic grid_wr;
    logic in_acc;
    logic div_start;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign grid_wr     = cfg_acc &&
                         (i_cfg.index == CFG_GRID_COLS || i_cfg.index == CFG_GRID_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_cell_w   <= SIZE_W'(16);
            r_cell_h   <= SIZE_W'(16);
            r_cols     <= GRID_W'(8);
            r_rows     <= GRID_W'(8);
        end else if (cfg_acc) begin
            case (i_cfg.index)
                CFG_ORIGIN_X:    r_origin_x <= i_cfg.data;
                CFG_ORIGIN_Y:    r_origin_y <= i_cfg.data;
                CFG_CELL_WIDTH:  r_cell_w   <= i_cfg.data[SIZE_W-1:0];
                CFG_CELL_HEIGHT: r_cell_h   <= i_cfg.data[SIZE_W-1:0];
                CFG_GRID_COLS:   r_cols     <= i_cfg.data[GRID_W-1:0];
                CFG_GRID_ROWS:   r_rows     <= i_cfg.data[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // Last active column and row after the grid size limits
    logic [XW-1:0] lim_x;
    logic [YW-1:0] lim_y;

    always_comb begin
        if (r_cols == '0) begin
            lim_x = '0;
        end else if (int'(r_cols) > MAX_COLS) begin
            lim_x = XW'(MAX_COLS - 1);
        end else begin
            lim_x = XW'(int'(r_cols) - 1);
        end
        if (r_rows == '0) begin
            lim_y = '0;
        end else if (int'(r_rows) > MAX_ROWS) begin
            lim_y = YW'(MAX_ROWS - 1);
        end else begin
            lim_y = YW'(int'(r_rows) - 1);
        end
    end

    // Four bin lanes, one per box edge
    logic          done_x0, done_x1, done_y0, done_y1;
    logic          div_done_all;
    logic [XW-1:0] bin_x0, bin_x1;
    logic [YW-1:0] bin_y0, bin_y1;

    gbai_bin_div #(.IDX_W(XW)) u_div_x0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_coord(i_in.min_x), .i_origin(r_origin_x), .i_size(r_cell_w),
        .i_lim(lim_x), .o_done(done_x0), .o_bin(bin_x0)
    );

    gbai_bin_div #(.IDX_W(XW)) u_div_x1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_coord(i_in.max_x), .i_origin(r_origin_x), .i_size(r_cell_w),
        .i_lim(lim_x), .o_done(done_x1), .o_bin(bin_x1)
    );

    gbai_bin_div #(.IDX_W(YW)) u_div_y0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_coord(i_in.min_y), .i_origin(r_origin_y), .i_size(r_cell_h),
        .i_lim(lim_y), .o_done(done_y0), .o_bin(bin_y0)
    );

    gbai_bin_div #(.IDX_W(YW)) u_div_y1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_coord(i_in.max_y), .i_origin(r_origin_y), .i_size(r_cell_h),
        .i_lim(lim_y), .o_done(done_y1), .o_bin(bin_y1)
    );

    assign div_done_all = done_x0 && done_x1 && done_y0 && done_y1;

    // Fill-count memory
    logic          mem_rd_en;
    logic [AW-1:0] cell_addr;
    logic [FW-1:0] rd_fill;
    logic [AW-1:0] wr_addr;
    logic          fill_we;
    logic [FW-1:0] fill_wdata;
    logic          store_we;
    logic [ID_W-1:0] r_id;

    gbai_cell_mem #(
        .NUM_CELLS(NUM_CELLS),
        .CELL_CAPACITY(CELL_CAPACITY)
    ) u_cell_mem (
        .i_clk(i_clk),
        .i_rd_en(mem_rd_en),
        .i_rd_addr(cell_addr),
        .o_rd_data(rd_fill),
        .i_wr_addr(wr_addr),
        .i_fill_we(fill_we),
        .i_fill_data(fill_wdata),
        .i_store_we(store_we),
        .i_store_slot(rd_fill),
        .i_store_data(r_id)
    );

    // Sequencer registers
    t_state        r_state, n_state;
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic [NW-1:0] r_n, n_n;
    logic [AW-1:0] r_clr, n_clr;

    // Output register
    logic                 r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_x;
    logic [OUT_IDX_W-1:0] r_out_y;
    logic [ID_W-1:0]      r_out_id;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_ovf;
    logic                 r_out_last;

    logic out_free;
    logic out_load;
    logic cell_full;
    logic rec_last;

    assign i_in.ready = (r_state == ST_IDLE) && !grid_wr;
    assign in_acc     = i_in.valid && i_in.ready;
    assign div_start  = in_acc && (i_in.func == FUNC_INSERT);

    assign cell_addr  = AW'(int'(r_x) * MAX_ROWS + int'(r_y));
    assign out_free   = !r_out_valid || o_out.ready;
    assign cell_full  = (rd_fill >= FW'(CELL_CAPACITY));
    assign rec_last   = ((r_x == bin_x1) && (r_y == bin_y1)) ||
                        (r_n == NW'(MAX_RESULTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_n <= n_n;
        if (in_acc) begin
            r_id <= i_in.collider_id;
        end
    end

    // Next state, memory strobes and record load
    always_comb begin
        n_state    = r_state;
        n_x        = r_x;
        n_y        = r_y;
        n_n        = r_n;
        n_clr      = r_clr;
        mem_rd_en  = 1'b0;
        wr_addr    = cell_addr;
        fill_we    = 1'b0;
        fill_wdata = rd_fill + FW'(1);
        store_we   = 1'b0;
        out_load   = 1'b0;

        case (r_state)
            ST_CLR: begin
                wr_addr    = r_clr;
                fill_we    = 1'b1;
                fill_wdata = '0;
                n_clr      = r_clr + AW'(1);
                if (r_clr == AW'(NUM_CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.func == FUNC_CLEAR) begin
                        n_state = ST_CLR;
                        n_clr   = '0;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done_all) begin
                    if ((bin_x0 > bin_x1) || (bin_y0 > bin_y1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_x     = bin_x0;
                        n_y     = bin_y0;
                        n_n     = '0;
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                mem_rd_en = 1'b1;
                n_state   = ST_WR;
            end
            ST_WR: begin
                if (out_free) begin
                    out_load = 1'b1;
                    fill_we  = !cell_full;
                    store_we = !cell_full;
                    if (rec_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_n     = r_n + NW'(1);
                        n_state = ST_RD;
                        if (r_y == bin_y1) begin
                            n_y = bin_y0;
                            n_x = r_x + XW'(1);
                        end else begin
                            n_y = r_y + YW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Grid size change empties every cell
        if (grid_wr) begin
            n_state = ST_CLR;
            n_clr   = '0;
        end
    end

    // Hold the record until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x    <= OUT_IDX_W'(r_x);
            r_out_y    <= OUT_IDX_W'(r_y);
            r_out_id   <= r_id;
            r_out_slot <= cell_full ? '0 : SLOT_W'(rd_fill);
            r_out_ovf  <= cell_full;
            r_out_last <= rec_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.cell_x   = r_out_x;
    assign o_out.cell_y   = r_out_y;
    assign o_out.echo_id  = r_out_id;
    assign o_out.slot     = r_out_slot;
    assign o_out.overflow = r_out_ovf;
    assign o_out.last     = r_out_last;

    // Checks
    logic st_rd;
    logic cell_in_box;
    logic full_write;
    logic last_load;
    logic seq_rest;

    assign st_rd       = (r_state == ST_RD);
    assign cell_in_box = (r_x >= bin_x0) && (r_x <= bin_x1) &&
                         (r_y >= bin_y0) && (r_y <= bin_y1);
    assign full_write  = (r_state == ST_WR) && fill_we && cell_full;
    assign last_load   = out_load && rec_last;
    assign seq_rest    = (r_state == ST_IDLE) || (r_state == ST_CLR);

    `ASSERT_PROP(a_rd_after_div, i_clk, i_rst_n, st_rd |-> div_done_all, "lane busy at read")
    `ASSERT_PROP(a_cell_in_box, i_clk, i_rst_n, out_load |-> cell_in_box, "record outside box")
    `ASSERT_NEVER(a_fill_past_cap, i_clk, i_rst_n, full_write, "fill count past capacity")
    `ASSERT_PROP(a_last_ends_item, i_clk, i_rst_n, last_load |=> seq_rest, "ran past last record")

endmodule

`default_nettype wire

[tb/grid_bin_aabb_insert_unit_checker.sv]
`timescale 1ns / 1ps
// Checker for the grid binning unit: tracks config and cell fill, predicts and compares records.
module grid_bin_aabb_insert_unit_checker #(
    parameter int MAX_COLS      = 8,
    parameter int MAX_ROWS      = 8,
    parameter int CELL_CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gbai_cfg_if  i_cfg,
    gbai_in_if   i_in,
    gbai_out_if  i_rec,
    output int   o_errors,
    output int   o_pending
);
    import gbai_pkg::*;

    localparam int NUM_CELLS  = MAX_COLS * MAX_ROWS;
    localparam int REPORT_MAX = 30;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] cell_x;
        logic [OUT_IDX_W-1:0] cell_y;
        logic [ID_W-1:0]      echo_id;
        logic [SLOT_W-1:0]    slot;
        logic                 overflow;
        logic                 last;
    } t_cell_rec;

    // Shadow copy of the grid registers and the per-cell fill counts
    logic signed [COORD_W-1:0] grid_org_x;
    logic signed [COORD_W-1:0] grid_org_y;
    logic [SIZE_W-1:0]         grid_cw;
    logic [SIZE_W-1:0]         grid_ch;
    logic [GRID_W-1:0]         grid_cols;
    logic [GRID_W-1:0]         grid_rows;
    int                        cell_fill [NUM_CELLS];
    t_cell_rec                 recs_due [$];

    function automatic int active_count(logic [GRID_W-1:0] v, int limit);
        if (v == '0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    // Floor of (coord - origin) / size, clamped to the active range
    function automatic int cell_of(int coord, int org, int size, int n);
        int d;
        int s;
        int q;
        d = coord - org;
        s = (size == 0) ? 1 : size;
        q = d / s;
        if ((d % s) != 0 && d < 0) q = q - 1;
        if (q < 0) q = 0;
        if (q > n - 1) q = n - 1;
        return q;
    endfunction

    task automatic empty_cells();
        foreach (cell_fill[i]) cell_fill[i] = 0;
    endtask

    task automatic write_shadow(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ORIGIN_X:    grid_org_x = data;
            CFG_ORIGIN_Y:    grid_org_y = data;
            CFG_CELL_WIDTH:  grid_cw = data[SIZE_W-1:0];
            CFG_CELL_HEIGHT: grid_ch = data[SIZE_W-1:0];
            CFG_GRID_COLS: begin
                grid_cols = data[GRID_W-1:0];
                empty_cells();
            end
            CFG_GRID_ROWS: begin
                grid_rows = data[GRID_W-1:0];
                empty_cells();
            end
            default: ;
        endcase
    endtask

    // Walk the covered cells column-major and queue one record per cell
    task automatic bin_box(logic [ID_W-1:0] id, int mnx, int mny, int mxx, int mxy);
        int        cols;
        int        rows;
        int        x0;
        int        x1;
        int        y0;
        int        y1;
        int        n;
        int        cell_idx;
        t_cell_rec rec;
        t_cell_rec batch [$];
        cols = active_count(grid_cols, MAX_COLS);
        rows = active_count(grid_rows, MAX_ROWS);
        x0 = cell_of(mnx, int'(grid_org_x), int'(grid_cw), cols);
        y0 = cell_of(mny, int'(grid_org_y), int'(grid_ch), rows);
        x1 = cell_of(mxx, int'(grid_org_x), int'(grid_cw), cols);
        y1 = cell_of(mxy, int'(grid_org_y), int'(grid_ch), rows);
        n = 0;
        for (int x = x0; x <= x1; x++) begin
            for (int y = y0; y <= y1; y++) begin
                if (n >= MAX_RESULTS) break;
                cell_idx = x * MAX_ROWS + y;
                rec.cell_x   = OUT_IDX_W'(x);
                rec.cell_y   = OUT_IDX_W'(y);
                rec.echo_id  = id;
                rec.last     = 1'b0;
                if (cell_fill[cell_idx] >= CELL_CAPACITY) begin
                    rec.slot     = '0;
                    rec.overflow = 1'b1;
                end else begin
                    rec.slot     = SLOT_W'(cell_fill[cell_idx]);
                    rec.overflow = 1'b0;
                    cell_fill[cell_idx] = cell_fill[cell_idx] + 1;
                end
                batch.insert(batch.size(), rec);
                n++;
            end
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) recs_due.insert(recs_due.size(), batch[i]);
    endtask

    task automatic flag(string fld, int want, int got);
        if (o_errors < REPORT_MAX)
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fld, want, got);
        o_errors++;
    endtask

    task automatic check_rec(t_cell_rec got);
        t_cell_rec want;
        if (recs_due.size() == 0) begin
            if (o_errors < REPORT_MAX)
                $display("%0t ns: unexpected record, expected none, actual x=%0d y=%0d id=0x%0h",
                         $time, got.cell_x, got.cell_y, got.echo_id);
            o_errors++;
        end else begin
            want = recs_due.pop_front();
            if (got.cell_x != want.cell_x) flag("cell_x", want.cell_x, got.cell_x);
            if (got.cell_y != want.cell_y) flag("cell_y", want.cell_y, got.cell_y);
            if (got.echo_id != want.echo_id) flag("echo_id", want.echo_id, got.echo_id);
            if (got.slot != want.slot) flag("slot", want.slot, got.slot);
            if (got.overflow != want.overflow) flag("overflow", want.overflow, got.overflow);
            if (got.last != want.last) flag("last", want.last, got.last);
        end
    endtask

    // Sample every channel on the rising edge; an item sees the registers before this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grid_org_x = '0;
            grid_org_y = '0;
            grid_cw    = SIZE_W'(16);
            grid_ch    = SIZE_W'(16);
            grid_cols  = GRID_W'(8);
            grid_rows  = GRID_W'(8);
            empty_cells();
            recs_due.delete();
            o_errors = 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (i_in.func == FUNC_CLEAR)
                    empty_cells();
                else
                    bin_box(i_in.collider_id, int'(i_in.min_x), int'(i_in.min_y),
                            int'(i_in.max_x), int'(i_in.max_y));
            end
            if (i_cfg.valid && i_cfg.ready)
                write_shadow(i_cfg.index, i_cfg.data);
            if (i_rec.valid && i_rec.ready)
                check_rec({i_rec.cell_x, i_rec.cell_y, i_rec.echo_id, i_rec.slot,
                           i_rec.overflow, i_rec.last});
        end
        o_pending = recs_due.size();
    end

endmodule

[tb/grid_bin_aabb_insert_unit_test.sv]
`timescale 1ns / 1ps
// Testbench top for the grid binning unit: clock, reset, stimulus, watchdog and verdict.
module grid_bin_aabb_insert_unit_test;
    import gbai_pkg::*;

    localparam int GRID_MAX    = 8;
    localparam int CAPACITY    = 16;
    localparam int GAP_MAX     = 17;
    localparam int DRAIN_WAIT  = 100;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 30;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gbai_cfg_if cfg_bus ();
    gbai_in_if  item_bus ();
    gbai_out_if rec_bus ();

    int fail_count;
    int rec_pending;
    int quiet_cycles = 0;
    bit item_burst   = 1'b0;
    bit rec_burst    = 1'b0;

    // Grid as currently programmed, used to aim boxes at the cells
    int org_x      = 0;
    int org_y      = 0;
    int width_eff  = 16;
    int height_eff = 16;
    int cols_eff   = GRID_MAX;
    int rows_eff   = GRID_MAX;

    always #5 i_clk = ~i_clk;

    grid_bin_aabb_insert_unit #(
        .MAX_COLS      (GRID_MAX),
        .MAX_ROWS      (GRID_MAX),
        .CELL_CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (item_bus),
        .o_out   (rec_bus)
    );

    grid_bin_aabb_insert_unit_checker #(
        .MAX_COLS      (GRID_MAX),
        .MAX_ROWS      (GRID_MAX),
        .CELL_CAPACITY (CAPACITY)
    ) bin_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_bus),
        .i_in      (item_bus),
        .i_rec     (rec_bus),
        .o_errors  (fail_count),
        .o_pending (rec_pending)
    );

    // Count cycles with no transaction on any channel; end the run when stuck
    always @(posedge i_clk) begin
        if ((cfg_bus.valid && cfg_bus.ready) || (item_bus.valid && item_bus.ready) ||
            (rec_bus.valid && rec_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stall the record channel for a random number of cycles before each transaction
    initial begin
        int gap;
        rec_bus.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            gap = rec_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                rec_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rec_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(rec_bus.valid && rec_bus.ready));
            @(negedge i_clk);
        end
    end

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    function automatic int sat16(int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    function automatic int active_count(logic [GRID_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > GRID_MAX) return GRID_MAX;
        return int'(v);
    endfunction

    // Coordinate on or near the grid, one cell beyond either edge at most
    function automatic int near_coord(int org, int sz, int n);
        int k;
        int off;
        k = $urandom_range(0, n + 1);
        case ($urandom_range(0, 3))
            0:       off = 0;
            1:       off = sz - 1;
            default: off = $urandom_range(0, sz - 1);
        endcase
        return sat16(org + (k - 1) * sz + off);
    endfunction

    // Write one register; leaves valid high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        cfg_bus.valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        @(negedge i_clk);
    endtask

    // Drop the item valid and wait until every record is back and the block is idle
    task automatic drain();
        item_bus.valid <= 1'b0;
        do @(negedge i_clk); while (rec_pending != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic program_grid(logic [15:0] ox, logic [15:0] oy, logic [15:0] cw,
                                logic [15:0] ch, logic [15:0] cols, logic [15:0] rows,
                                bit grid_too);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_CELL_WIDTH, cw);
        write_reg(CFG_CELL_HEIGHT, ch);
        if (grid_too) begin
            write_reg(CFG_GRID_COLS, cols);
            write_reg(CFG_GRID_ROWS, rows);
            cols_eff = active_count(cols[GRID_W-1:0]);
            rows_eff = active_count(rows[GRID_W-1:0]);
        end
        org_x      = int'($signed(ox));
        org_y      = int'($signed(oy));
        width_eff  = (cw[SIZE_W-1:0] == '0) ? 1 : int'(cw[SIZE_W-1:0]);
        height_eff = (ch[SIZE_W-1:0] == '0) ? 1 : int'(ch[SIZE_W-1:0]);
    endtask

    // Send one item after a random gap; with hold set, wait for all records first
    task automatic send_item(logic func, logic [ID_W-1:0] id,
                             logic [15:0] mnx, logic [15:0] mny,
                             logic [15:0] mxx, logic [15:0] mxy, bit hold);
        int gap;
        gap = item_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0 || hold) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (hold) begin
            do @(negedge i_clk); while (rec_pending != 0);
        end
        item_bus.func        <= func;
        item_bus.collider_id <= id;
        item_bus.min_x       <= mnx;
        item_bus.min_y       <= mny;
        item_bus.max_x       <= mxx;
        item_bus.max_y       <= mxy;
        item_bus.valid       <= 1'b1;
        do @(posedge i_clk); while (!(item_bus.valid && item_bus.ready));
        @(negedge i_clk);
    endtask

    // Mostly boxes aimed at the grid, some raw noise and a few clears
    task automatic send_random();
        int r;
        int xa;
        int xb;
        int ya;
        int yb;
        int t;
        bit hold;
        r    = $urandom_range(0, 99);
        hold = ($urandom_range(0, 39) == 0);
        if (r < 5) begin
            send_item(FUNC_CLEAR, rand16(), rand16(), rand16(), rand16(), rand16(), hold);
        end else if (r < 25) begin
            send_item(FUNC_INSERT, rand16(), rand16(), rand16(), rand16(), rand16(), hold);
        end else begin
            xa = near_coord(org_x, width_eff, cols_eff);
            ya = near_coord(org_y, height_eff, rows_eff);
            xb = $urandom_range(0, 1) ? near_coord(org_x, width_eff, cols_eff)
                                      : sat16(xa + int'($urandom_range(0, width_eff)));
            yb = $urandom_range(0, 1) ? near_coord(org_y, height_eff, rows_eff)
                                      : sat16(ya + int'($urandom_range(0, height_eff)));
            // Keep most boxes well-formed; leave the rest possibly inverted
            if (r < 92) begin
                if (xa > xb) begin
                    t = xa; xa = xb; xb = t;
                end
                if (ya > yb) begin
                    t = ya; ya = yb; yb = t;
                end
            end
            send_item(FUNC_INSERT, rand16(), 16'(xa), 16'(ya), 16'(xb), 16'(yb), hold);
        end
    endtask

    function automatic logic [15:0] rand_origin();
        if ($urandom_range(0, 3) == 0) return rand16();
        return 16'(int'($urandom_range(0, 1024)) - 512);
    endfunction

    function automatic logic [15:0] rand_size();
        if ($urandom_range(0, 9) == 0) return rand16();
        return 16'($urandom_range(1, 48));
    endfunction

    initial begin
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = '0;
        cfg_bus.data         = '0;
        item_bus.valid       = 1'b0;
        item_bus.func        = FUNC_CLEAR;
        item_bus.collider_id = '0;
        item_bus.min_x       = '0;
        item_bus.min_y       = '0;
        item_bus.max_x       = '0;
        item_bus.max_y       = '0;

        // Hold reset, release on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items on the reset grid: 8 x 8 cells of 16 units from the origin
        send_item(FUNC_INSERT, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
        send_item(FUNC_INSERT, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_item(FUNC_INSERT, 16'h1234, 16'd50, 16'd0, 16'd20, 16'd40, 1'b0);
        send_item(FUNC_INSERT, 16'h4321, 16'd0, 16'd60, 16'd40, 16'd20, 1'b0);
        send_item(FUNC_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        // Fill one cell past capacity
        for (int i = 0; i <= CAPACITY; i++)
            send_item(FUNC_INSERT, 16'(16'hA500 + i), 16'd16, 16'd16, 16'd31, 16'd31, 1'b0);
        send_item(FUNC_INSERT, 16'h5A5A, 16'(-100), 16'(-100), 16'hFFFF, 16'hFFFF, 1'b0);
        send_item(FUNC_INSERT, 16'hC3C3, 16'd200, 16'd300, 16'h7FFF, 16'h7FFF, 1'b0);

        // Random phases, each on a fresh grid setting
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin
                    program_grid(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h000F, 16'h0000,
                                 1'b1);
                    write_reg(CFG_SPARE_A, rand16());
                    write_reg(CFG_SPARE_B, rand16());
                end
                1: program_grid(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0001, 16'h0001, 16'h0008,
                                1'b1);
                2: program_grid(16'h0000, 16'h0000, 16'h8001, 16'hFFFF, 16'hFFF2, 16'h0003,
                                1'b1);
                default: program_grid(rand_origin(), rand_origin(), rand_size(), rand_size(),
                                      16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                                      (p == 3) || ($urandom_range(0, 1) == 1));
            endcase
            cfg_bus.valid <= 1'b0;
            item_burst = ($urandom_range(0, 3) == 0);
            rec_burst  = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) send_random();
        end

        drain();
        if (fail_count == 0 && rec_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
